@@ hw/rtl/scru_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scru_pkg
// shared types, constants and codes of the simplex code rank / unrank block
// ----------------------------------------------------------------------------
package scru_pkg;

  // table geometry
  localparam int MAX_POINTS = 256;
  localparam int MAX_K      = 8;
  localparam int N_W        = $clog2(MAX_POINTS + 1);  // row index 0..MAX_POINTS
  localparam int K_W        = $clog2(MAX_K + 1);       // column index 0..MAX_K
  localparam int DEPTH      = MAX_POINTS + 1;

  // fixed field widths
  localparam int LABEL_W  = 16;
  localparam int CODE_W   = 63;
  localparam int BIN_W    = 64;
  localparam int DIM_W    = 3;
  localparam int VERTEX_W = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 9;
  localparam int SIZE_W   = 4;
  localparam int OFF_W    = 16;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [BIN_W-1:0] BIN_SAT = {1'b1, {(BIN_W-1){1'b0}}};

  // register indexes
  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_MAX_SET_SIZE  = 2'd1;
  localparam logic [1:0] REG_VERTEX_OFFSET = 2'd2;

  localparam logic [CNT_W-1:0]  VERTEX_COUNT_RST  = CNT_W'(256);
  localparam logic [SIZE_W-1:0] MAX_SET_SIZE_RST  = SIZE_W'(8);
  localparam logic [OFF_W-1:0]  VERTEX_OFFSET_RST = '0;

  // operations and result kinds
  localparam logic OP_ENCODE   = 1'b0;
  localparam logic OP_DECODE   = 1'b1;
  localparam logic KIND_CODE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [LABEL_W-1:0] vertex_label;
    logic               last_vertex;
    logic [CODE_W-1:0]  code_in;
    logic [DIM_W-1:0]   dimension;
  } item_t;

  typedef struct packed {
    logic                kind;
    logic [CODE_W-1:0]   code_out;
    logic [VERTEX_W-1:0] vertex_out;
    logic                last_result;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  vertex_count;
    logic [SIZE_W-1:0] max_set_size;
    logic [OFF_W-1:0]  vertex_offset;
  } cfg_t;

  // one table row: C(n, 0..MAX_K)
  typedef logic [MAX_K:0][BIN_W-1:0] row_t;

  typedef enum logic [1:0] {
    RD_VERTEX,
    RD_COUNT,
    RD_MID,
    RD_HIGH
  } rd_src_t;

  typedef enum logic [1:0] {
    OUT_CODE,
    OUT_VERTEX,
    OUT_SIZE_ERR,
    OUT_RANGE_ERR
  } out_sel_t;

  typedef struct packed {
    logic     fill;
    logic     load;
    rd_src_t  rd_src;
    logic     enc_update;
    logic     enc_clear;
    logic     dec_start;
    logic     search_step;
    logic     dec_sub;
    logic     dec_next;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic in_decode;
    logic last_vertex;
    logic size_bad;
    logic range_bad;
    logic search_more;
    logic last_k;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/scru_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scru_dpath
// binomial table memory with fill engine, encode accumulator, decode search
// registers and the result register
// ----------------------------------------------------------------------------
module scru_dpath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scru_pkg::cmd_t   cmd,
  output scru_pkg::stat_t       st,
  input  wire scru_pkg::cfg_t   cfg,
  input  wire scru_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output scru_pkg::result_t     result
);

  // saturating pascal step, all columns side by side
  function automatic scru_pkg::row_t pascal_next(scru_pkg::row_t r);
    scru_pkg::row_t             nr;
    logic [scru_pkg::BIN_W:0]   s;
    nr    = '0;
    nr[0] = scru_pkg::BIN_W'(1);
    for (int j = 1; j <= scru_pkg::MAX_K; j++) begin
      s = {1'b0, r[j-1]} + {1'b0, r[j]};
      nr[j] = (s >= {1'b0, scru_pkg::BIN_SAT}) ? scru_pkg::BIN_SAT : s[scru_pkg::BIN_W-1:0];
    end
    return nr;
  endfunction

  function automatic logic [scru_pkg::BIN_W-1:0] bin_col(scru_pkg::row_t r,
                                                          logic [scru_pkg::SIZE_W:0] c);
    logic [scru_pkg::BIN_W-1:0] v;
    v = '0;
    if (c <= (scru_pkg::SIZE_W+1)'(scru_pkg::MAX_K)) begin
      v = r[c[scru_pkg::K_W-1:0]];
    end
    return v;
  endfunction

  // table fill
  logic [scru_pkg::N_W-1:0] fill_cnt;
  scru_pkg::row_t           fill_row;
  scru_pkg::row_t           mem [scru_pkg::DEPTH];
  scru_pkg::row_t           rd_row;
  logic [scru_pkg::N_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt    <= '0;
      fill_row    <= '0;
      fill_row[0] <= scru_pkg::BIN_W'(1);
    end else if (cmd.fill) begin
      fill_cnt <= fill_cnt + scru_pkg::N_W'(1);
      fill_row <= pascal_next(fill_row);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      mem[fill_cnt] <= fill_row;
    end
    rd_row <= mem[rd_addr];
  end

  // effective configuration
  logic [scru_pkg::N_W-1:0]    n_eff;
  logic [scru_pkg::SIZE_W-1:0] size_eff;

  always_comb begin
    if (cfg.vertex_count == '0) begin
      n_eff = scru_pkg::N_W'(1);
    end else if (cfg.vertex_count > scru_pkg::CNT_W'(scru_pkg::MAX_POINTS)) begin
      n_eff = scru_pkg::N_W'(scru_pkg::MAX_POINTS);
    end else begin
      n_eff = scru_pkg::N_W'(cfg.vertex_count);
    end
    if (cfg.max_set_size == '0) begin
      size_eff = scru_pkg::SIZE_W'(1);
    end else if ({1'b0, cfg.max_set_size} > (scru_pkg::SIZE_W+1)'(scru_pkg::MAX_K)) begin
      size_eff = scru_pkg::SIZE_W'(scru_pkg::MAX_K);
    end else begin
      size_eff = cfg.max_set_size;
    end
  end

  // item and encode state
  scru_pkg::item_t                item_q;
  logic [scru_pkg::CODE_W-1:0]    running;
  logic [scru_pkg::SIZE_W-1:0]    set_pos;
  logic [scru_pkg::N_W-2:0]       prev_v;
  logic                           prev_valid;
  logic [scru_pkg::STATUS_W-1:0]  sticky;

  logic [scru_pkg::OFF_W-1:0]     vdiff;
  logic [scru_pkg::N_W-2:0]       vtx;
  logic                           vbad;
  logic                           order_bad;
  logic                           size_bad_e;
  logic [scru_pkg::SIZE_W:0]      kcol;
  logic [scru_pkg::BIN_W-1:0]     cval;
  logic [scru_pkg::BIN_W-1:0]     sum;
  logic [scru_pkg::STATUS_W-1:0]  enc_err;

  always_comb begin
    vdiff      = item_q.vertex_label - cfg.vertex_offset;
    vtx        = vdiff[scru_pkg::N_W-2:0];
    vbad       = (item_q.vertex_label < cfg.vertex_offset) ||
                 (vdiff >= scru_pkg::OFF_W'(n_eff));
    order_bad  = prev_valid && (vtx <= prev_v);
    size_bad_e = set_pos >= size_eff;
    kcol       = {1'b0, set_pos} + (scru_pkg::SIZE_W+1)'(1);
    cval       = bin_col(rd_row, kcol);
    sum        = {1'b0, running} + cval;
    if (vbad) begin
      enc_err = scru_pkg::ST_RANGE;
    end else if (order_bad) begin
      enc_err = scru_pkg::ST_ORDER;
    end else if (size_bad_e) begin
      enc_err = scru_pkg::ST_SIZE;
    end else if (sum[scru_pkg::BIN_W-1]) begin
      enc_err = scru_pkg::ST_OVERFLOW;
    end else begin
      enc_err = scru_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.enc_clear) begin
      running    <= '0;
      set_pos    <= '0;
      prev_v     <= '0;
      prev_valid <= 1'b0;
      sticky     <= scru_pkg::ST_OK;
    end else if (cmd.enc_update && sticky == scru_pkg::ST_OK) begin
      if (enc_err != scru_pkg::ST_OK) begin
        sticky <= enc_err;
      end else begin
        running    <= sum[scru_pkg::CODE_W-1:0];
        set_pos    <= set_pos + scru_pkg::SIZE_W'(1);
        prev_v     <= vtx;
        prev_valid <= 1'b1;
      end
    end
  end

  // decode search state
  logic [scru_pkg::CODE_W-1:0] dcode;
  logic [scru_pkg::SIZE_W-1:0] dk;
  logic [scru_pkg::N_W-1:0]    lo;
  logic [scru_pkg::N_W-1:0]    h;
  logic [scru_pkg::N_W:0]      mid_sum;
  logic [scru_pkg::N_W-1:0]    mid;
  logic [scru_pkg::BIN_W-1:0]  dval;

  always_comb begin
    mid_sum = {1'b0, h} + {1'b0, lo};
    mid     = mid_sum[scru_pkg::N_W:1];
    dval    = bin_col(rd_row, {1'b0, dk});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dcode <= item.code_in;
      dk    <= scru_pkg::SIZE_W'(item.dimension) + scru_pkg::SIZE_W'(1);
    end
    if (cmd.dec_start) begin
      lo <= scru_pkg::N_W'(dk) - scru_pkg::N_W'(1);
      h  <= n_eff;
    end
    if (cmd.search_step) begin
      if (dval <= {1'b0, dcode}) begin
        lo <= mid + scru_pkg::N_W'(1);
      end else begin
        h <= mid;
      end
    end
    if (cmd.dec_sub) begin
      dcode <= dcode - dval[scru_pkg::CODE_W-1:0];
      h     <= h - scru_pkg::N_W'(1);
    end
    if (cmd.dec_next) begin
      dk <= dk - scru_pkg::SIZE_W'(1);
      lo <= scru_pkg::N_W'(dk) - scru_pkg::N_W'(2);
    end
  end

  always_comb begin
    case (cmd.rd_src)
      scru_pkg::RD_VERTEX: rd_addr = scru_pkg::N_W'(vtx);
      scru_pkg::RD_COUNT:  rd_addr = n_eff;
      scru_pkg::RD_MID:    rd_addr = mid;
      scru_pkg::RD_HIGH:   rd_addr = h - scru_pkg::N_W'(1);
      default:             rd_addr = n_eff;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.code_out    <= '0;
      result.vertex_out  <= '0;
      result.last_result <= 1'b1;
      case (cmd.out_sel)
        scru_pkg::OUT_CODE: begin
          result.kind     <= scru_pkg::KIND_CODE;
          result.code_out <= (sticky == scru_pkg::ST_OK) ? running : '0;
          result.status   <= sticky;
        end
        scru_pkg::OUT_VERTEX: begin
          result.kind        <= scru_pkg::KIND_VERTEX;
          result.vertex_out  <= scru_pkg::VERTEX_W'(h);
          result.last_result <= (dk == scru_pkg::SIZE_W'(1));
          result.status      <= scru_pkg::ST_OK;
        end
        scru_pkg::OUT_SIZE_ERR: begin
          result.kind   <= scru_pkg::KIND_VERTEX;
          result.status <= scru_pkg::ST_SIZE;
        end
        default: begin
          result.kind   <= scru_pkg::KIND_VERTEX;
          result.status <= scru_pkg::ST_RANGE;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    st.fill_done   = (fill_cnt == scru_pkg::N_W'(scru_pkg::MAX_POINTS));
    st.in_decode   = (item.operation == scru_pkg::OP_DECODE);
    st.last_vertex = item_q.last_vertex;
    st.size_bad    = dk > size_eff;
    st.range_bad   = {1'b0, dcode} >= dval;
    st.search_more = h > lo;
    st.last_k      = (dk == scru_pkg::SIZE_W'(1));
    st.out_free    = !result_valid || result_ready;
  end

endmodule
`default_nettype wire

@@ hw/rtl/scru_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scru_ctrl
// sequencer for table fill, encode steps and the decode binary searches
// ----------------------------------------------------------------------------
module scru_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire scru_pkg::stat_t st,
  output scru_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_ENC_RD,
    S_ENC_UPD,
    S_ENC_EMIT,
    S_DEC_CHK,
    S_DEC_RANGE,
    S_DEC_RD,
    S_DEC_CMP,
    S_DEC_SUB,
    S_DEC_EMIT,
    S_ERR_SIZE,
    S_ERR_RANGE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = st.in_decode ? S_DEC_CHK : S_ENC_RD;
        end
      end
      S_ENC_RD: begin
        cmd.rd_src = scru_pkg::RD_VERTEX;
        state_next = S_ENC_UPD;
      end
      S_ENC_UPD: begin
        cmd.enc_update = 1'b1;
        state_next     = st.last_vertex ? S_ENC_EMIT : S_IDLE;
      end
      S_ENC_EMIT: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = scru_pkg::OUT_CODE;
          cmd.enc_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DEC_CHK: begin
        cmd.rd_src = scru_pkg::RD_COUNT;
        state_next = st.size_bad ? S_ERR_SIZE : S_DEC_RANGE;
      end
      S_DEC_RANGE: begin
        if (st.range_bad) begin
          state_next = S_ERR_RANGE;
        end else begin
          cmd.dec_start = 1'b1;
          state_next    = S_DEC_RD;
        end
      end
      S_DEC_RD: begin
        cmd.rd_src = st.search_more ? scru_pkg::RD_MID : scru_pkg::RD_HIGH;
        state_next = st.search_more ? S_DEC_CMP : S_DEC_SUB;
      end
      S_DEC_CMP: begin
        cmd.search_step = 1'b1;
        state_next      = S_DEC_RD;
      end
      S_DEC_SUB: begin
        cmd.dec_sub = 1'b1;
        state_next  = S_DEC_EMIT;
      end
      S_DEC_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = scru_pkg::OUT_VERTEX;
          cmd.dec_next = 1'b1;
          state_next   = st.last_k ? S_IDLE : S_DEC_RD;
        end
      end
      S_ERR_SIZE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = scru_pkg::OUT_SIZE_ERR;
          state_next   = S_IDLE;
        end
      end
      S_ERR_RANGE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = scru_pkg::OUT_RANGE_ERR;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while the result register is occupied");

  a_sub_after_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC_SUB) |-> !st.search_more)
    else $error("subtract step entered with search interval still open");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC_CMP) |-> $past(st.search_more))
    else $error("compare step without a midpoint read");

  a_emit_after_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC_EMIT) |-> ($past(state) == S_ENC_UPD || $past(state) == S_ENC_EMIT))
    else $error("code result without a preceding accumulate step");

endmodule
`default_nettype wire

@@ hw/rtl/simplex_code_rank_unrank.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_code_rank_unrank
// ranks ascending vertex sets into combinatorial codes and unranks codes into
// vertices, largest first, over a pascal-triangle table held in a memory
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+------------------------
//  item     | item_valid, item_ready, item (item_t)    | item_valid & item_ready
//  result   | result_valid, result_ready, result       | result_valid & result_ready
//  config   | psel, penable, pwrite, paddr, pwdata,    | psel & penable & pwrite
//           | prdata, pready (always high)             |   (regs at 0x0, 0x4, 0x8)
//
//  after reset the table is built one row a cycle with item_ready low; config
//  writes are taken during that time
//  encode: per vertex a load, a table read and an accumulate step, plus an
//  emit step after the last mark (one table read)
//  decode: size and range checks, then per vertex a binary search of read and
//  compare steps, a read at the found row, a subtract step and an emit step
//  one item in flight; a held result stalls the sequencer only at its next load
module simplex_code_rank_unrank (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // item channel
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire scru_pkg::item_t                item,
  // result channel
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output scru_pkg::result_t                   result,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [scru_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [scru_pkg::PDATA_W-1:0]   pwdata,
  output logic      [scru_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  // configuration registers
  scru_pkg::cfg_t cfg;
  logic [1:0]     reg_idx;
  logic           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_count  <= scru_pkg::VERTEX_COUNT_RST;
      cfg.max_set_size  <= scru_pkg::MAX_SET_SIZE_RST;
      cfg.vertex_offset <= scru_pkg::VERTEX_OFFSET_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        scru_pkg::REG_VERTEX_COUNT:  cfg.vertex_count  <= pwdata[scru_pkg::CNT_W-1:0];
        scru_pkg::REG_MAX_SET_SIZE:  cfg.max_set_size  <= pwdata[scru_pkg::SIZE_W-1:0];
        scru_pkg::REG_VERTEX_OFFSET: cfg.vertex_offset <= pwdata[scru_pkg::OFF_W-1:0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      scru_pkg::REG_VERTEX_COUNT:  prdata = scru_pkg::PDATA_W'(cfg.vertex_count);
      scru_pkg::REG_MAX_SET_SIZE:  prdata = scru_pkg::PDATA_W'(cfg.max_set_size);
      scru_pkg::REG_VERTEX_OFFSET: prdata = scru_pkg::PDATA_W'(cfg.vertex_offset);
      default:                     prdata = '0;
    endcase
  end

  // controller / datapath split
  scru_pkg::cmd_t  cmd;
  scru_pkg::stat_t st;

  scru_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  scru_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg          (cfg),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ test/simplex_code_rank_unrank_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_code_rank_unrank_tb
// drives vertex sets and codes through the rank / unrank block, predicts every
// code and vertex from its own pascal table and checks each result transfer
// ----------------------------------------------------------------------------
module simplex_code_rank_unrank_tb;

  localparam logic [63:0] CODE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 5000;  // quiet cycles before the run is called hung
  localparam int SETTLE_CYCLES = 16;  // longer than an encode step without a result
  localparam int TAIL_CYCLES = 200;   // longer than one full decode

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_ready;
  scru_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  scru_pkg::result_t result;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [scru_pkg::PADDR_W-1:0] paddr = '0;
  logic [scru_pkg::PDATA_W-1:0] pwdata = '0;
  logic [scru_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // own copy of the binomial table, C(n, k) saturated at 2^63
  logic [63:0] pascal [0:scru_pkg::MAX_POINTS][0:scru_pkg::MAX_K];

  // register copies as last written
  logic [scru_pkg::CNT_W-1:0] cfg_points = scru_pkg::VERTEX_COUNT_RST;
  logic [scru_pkg::SIZE_W-1:0] cfg_set_size = scru_pkg::MAX_SET_SIZE_RST;
  logic [scru_pkg::OFF_W-1:0] cfg_offset = scru_pkg::VERTEX_OFFSET_RST;

  // state of the set being ranked
  logic [63:0] run_code = '0;
  int unsigned set_pos = 0;
  int unsigned prev_vertex = 0;
  bit prev_seen = 1'b0;
  logic [scru_pkg::STATUS_W-1:0] set_error = scru_pkg::ST_OK;

  // codes and vertices still to come out, oldest first
  scru_pkg::result_t code_vertex_q[$];
  scru_pkg::result_t oldest;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;  // no idling on either side while set

  simplex_code_rank_unrank dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // result side stalls about 36 percent of the time
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 36);
  end

  // ---------------------------------------------------------------- predictor

  // zero reads as one point, anything past the table as the full table
  function automatic int unsigned eff_points();
    if (cfg_points == 0) return 1;
    if (cfg_points > scru_pkg::MAX_POINTS) return scru_pkg::MAX_POINTS;
    return cfg_points;
  endfunction

  function automatic int unsigned eff_size();
    if (cfg_set_size == 0) return 1;
    if (cfg_set_size > scru_pkg::MAX_K) return scru_pkg::MAX_K;
    return cfg_set_size;
  endfunction

  function automatic logic [63:0] bin_at(input int unsigned row, input int unsigned col);
    if (col > row) return '0;
    if (row > scru_pkg::MAX_POINTS || col > scru_pkg::MAX_K) return scru_pkg::BIN_SAT;
    return pascal[row][col];
  endfunction

  // append one awaited result at the tail
  function automatic void add_pending(input scru_pkg::result_t r);
    code_vertex_q = {code_vertex_q, r};
  endfunction

  // work out what one accepted item produces and queue it
  function automatic void rank_or_unrank(input scru_pkg::item_t it);
    int unsigned n, v, k, lo, h, mid, hi;
    logic [63:0] c, code;
    scru_pkg::result_t r;
    n = eff_points();
    r = '0;
    if (it.operation == scru_pkg::OP_ENCODE) begin
      // first error of a set sticks, later vertices are ignored
      if (set_error == scru_pkg::ST_OK) begin
        v = 0;
        if (it.vertex_label < cfg_offset) begin
          set_error = scru_pkg::ST_RANGE;
        end else begin
          v = it.vertex_label - cfg_offset;
          if (v >= n) set_error = scru_pkg::ST_RANGE;
          else if (prev_seen && v <= prev_vertex) set_error = scru_pkg::ST_ORDER;
          else if (set_pos + 1 > eff_size()) set_error = scru_pkg::ST_SIZE;
        end
        if (set_error == scru_pkg::ST_OK) begin
          c = bin_at(v, set_pos + 1);
          if (c > CODE_MAX - run_code) begin
            set_error = scru_pkg::ST_OVERFLOW;
          end else begin
            run_code = run_code + c;
            set_pos++;
            prev_vertex = v;
            prev_seen = 1'b1;
          end
        end
      end
      if (it.last_vertex) begin
        r.kind = scru_pkg::KIND_CODE;
        r.code_out = (set_error == scru_pkg::ST_OK) ? run_code[scru_pkg::CODE_W-1:0] : '0;
        r.last_result = 1'b1;
        r.status = set_error;
        add_pending(r);
        run_code = '0;
        set_pos = 0;
        prev_vertex = 0;
        prev_seen = 1'b0;
        set_error = scru_pkg::ST_OK;
      end
    end else begin
      // decode leaves the open set alone
      k = it.dimension + 1;
      hi = n;
      code = {1'b0, it.code_in};
      r.kind = scru_pkg::KIND_VERTEX;
      r.last_result = 1'b1;
      if (k > eff_size()) begin
        r.status = scru_pkg::ST_SIZE;
        add_pending(r);
      end else if (code >= bin_at(n, k)) begin
        r.status = scru_pkg::ST_RANGE;
        add_pending(r);
      end else begin
        // largest vertex first, each search capped by the one before
        while (k > 0) begin
          lo = k - 1;
          h = hi;
          while (h > lo) begin
            mid = (h + lo) / 2;
            if (bin_at(mid, k) <= code) lo = mid + 1;
            else h = mid;
          end
          hi = h - 1;
          code = code - bin_at(hi, k);
          r.vertex_out = hi[scru_pkg::VERTEX_W-1:0];
          r.last_result = (k == 1);
          r.status = scru_pkg::ST_OK;
          add_pending(r);
          k--;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns mismatch %s: got %0h, want %0h", $time, what, seen, wanted);
  endtask

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (code_vertex_q.size() == 0) begin
        report_mismatch("result with nothing awaited", result.code_out, result.vertex_out);
      end else begin
        oldest = code_vertex_q.pop_front();
        if (result.kind !== oldest.kind)
          report_mismatch("kind", result.kind, oldest.kind);
        if (result.code_out !== oldest.code_out)
          report_mismatch("code_out", result.code_out, oldest.code_out);
        if (result.vertex_out !== oldest.vertex_out)
          report_mismatch("vertex_out", result.vertex_out, oldest.vertex_out);
        if (result.last_result !== oldest.last_result)
          report_mismatch("last_result", result.last_result, oldest.last_result);
        if (result.status !== oldest.status)
          report_mismatch("status", result.status, oldest.status);
      end
    end
  end

  // hang detection: no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // setup cycle, access cycle, then an idle cycle so writes never abut
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // register lands here, pready is always high
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      scru_pkg::REG_VERTEX_COUNT: cfg_points = value[scru_pkg::CNT_W-1:0];
      scru_pkg::REG_MAX_SET_SIZE: cfg_set_size = value[scru_pkg::SIZE_W-1:0];
      scru_pkg::REG_VERTEX_OFFSET: cfg_offset = value[scru_pkg::OFF_W-1:0];
      default: ;
    endcase
  endtask

  // valid stays high from one transfer into the next unless a gap is drawn
  task automatic send_item(input scru_pkg::item_t it);
    while (!steady && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    rank_or_unrank(it);
  endtask

  // fields that the operation does not use carry random junk
  task automatic send_encode(input logic [scru_pkg::LABEL_W-1:0] label, input logic last);
    scru_pkg::item_t it;
    it.operation = scru_pkg::OP_ENCODE;
    it.vertex_label = label;
    it.last_vertex = last;
    it.code_in = scru_pkg::CODE_W'({$urandom, $urandom});
    it.dimension = scru_pkg::DIM_W'($urandom);
    send_item(it);
  endtask

  task automatic send_decode(input logic [scru_pkg::CODE_W-1:0] code,
                             input logic [scru_pkg::DIM_W-1:0] dim);
    scru_pkg::item_t it;
    it.operation = scru_pkg::OP_DECODE;
    it.vertex_label = scru_pkg::LABEL_W'($urandom);
    it.last_vertex = 1'($urandom);
    it.code_in = code;
    it.dimension = dim;
    send_item(it);
  endtask

  // drop valid, let every awaited result arrive, then give the block time
  task automatic wait_idle(input int tail);
    item_valid <= 1'b0;
    while (code_vertex_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic random_config();
    logic [scru_pkg::CNT_W-1:0] pts;
    logic [scru_pkg::SIZE_W-1:0] sz;
    logic [scru_pkg::OFF_W-1:0] off;
    case ($urandom_range(5))
      0: pts = '0;
      1: pts = '1;
      2: pts = scru_pkg::CNT_W'($urandom_range(1, 4));
      default: pts = scru_pkg::CNT_W'($urandom_range(1, scru_pkg::MAX_POINTS));
    endcase
    case ($urandom_range(5))
      0: sz = '0;
      1: sz = scru_pkg::SIZE_W'($urandom_range(scru_pkg::MAX_K + 1, 15));
      2: sz = scru_pkg::SIZE_W'(1);
      default: sz = scru_pkg::SIZE_W'($urandom_range(1, scru_pkg::MAX_K));
    endcase
    case ($urandom_range(7))
      0: off = '1;
      1: off = scru_pkg::OFF_W'($urandom);
      2, 3: off = scru_pkg::OFF_W'($urandom_range(1, 300));
      default: off = '0;
    endcase
    cfg_write(scru_pkg::REG_VERTEX_COUNT, 32'(pts));
    cfg_write(scru_pkg::REG_MAX_SET_SIZE, 32'(sz));
    cfg_write(scru_pkg::REG_VERTEX_OFFSET, 32'(off));
  endtask

  // mostly ascending sets and decodable codes, the rest broken sets and junk
  task automatic random_items(input int total);
    int sent, pick, s, cnt, i;
    int unsigned n, k, v, tmp;
    int unsigned verts[$];
    logic [scru_pkg::MAX_POINTS-1:0] chosen;
    logic [63:0] lim, seed, code;
    sent = 0;
    while (sent < total) begin
      n = eff_points();
      pick = $urandom_range(99);
      if (pick < 55) begin
        // one vertex too many now and then
        s = $urandom_range(1, eff_size());
        if ($urandom_range(9) == 0) s++;
        if (s > n) s = n;
        chosen = '0;
        cnt = 0;
        while (cnt < s) begin
          v = $urandom_range(n - 1);
          if (!chosen[v]) begin
            chosen[v] = 1'b1;
            cnt++;
          end
        end
        verts.delete();
        for (v = 0; v < n; v++)
          if (chosen[v]) verts = {verts, v};
        // out of order set
        if (verts.size() > 1 && $urandom_range(7) == 0) begin
          tmp = verts[0];
          verts[0] = verts[verts.size() - 1];
          verts[verts.size() - 1] = tmp;
        end
        for (i = 0; i < verts.size(); i++)
          send_encode(scru_pkg::LABEL_W'(verts[i] + cfg_offset), i == verts.size() - 1);
        sent += verts.size();
      end else if (pick < 85) begin
        if ($urandom_range(4) == 0) k = $urandom_range(1, scru_pkg::MAX_K);
        else k = $urandom_range(1, eff_size());
        lim = bin_at(n, k);
        seed = {$urandom, $urandom} & CODE_MAX;
        case ($urandom_range(9))
          0: code = lim;  // first code past the end
          1: code = seed;
          2: code = (lim != 0) ? lim - 1 : '0;
          default: code = (lim != 0) ? seed % lim : seed;
        endcase
        send_decode(code[scru_pkg::CODE_W-1:0], scru_pkg::DIM_W'(k - 1));
        sent++;
      end else begin
        if ($urandom_range(1) == 0)
          send_encode(scru_pkg::LABEL_W'($urandom), $urandom_range(3) == 0);
        else
          send_encode(scru_pkg::LABEL_W'(cfg_offset + $urandom_range(n)),
                      $urandom_range(3) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // register reset values: extremes of the set, errors, decode inside a set
  task automatic test_reset_defaults();
    int v;
    send_encode(scru_pkg::LABEL_W'(255), 1'b1);
    for (v = 248; v <= 255; v++) send_encode(scru_pkg::LABEL_W'(v), v == 255);
    send_encode(scru_pkg::LABEL_W'(5), 1'b0);
    send_decode('0, scru_pkg::DIM_W'(0));        // open set must survive this
    send_encode(scru_pkg::LABEL_W'(5), 1'b1);    // repeat vertex, not ascending
    send_decode(scru_pkg::CODE_W'(pascal[scru_pkg::MAX_POINTS][scru_pkg::MAX_K] - 1),
                scru_pkg::DIM_W'(7));
    send_decode(scru_pkg::CODE_W'(pascal[scru_pkg::MAX_POINTS][scru_pkg::MAX_K]),
                scru_pkg::DIM_W'(7));
    send_decode('1, scru_pkg::DIM_W'(0));
    send_encode(scru_pkg::LABEL_W'(256), 1'b1);  // vertex past the point count
    wait_idle(SETTLE_CYCLES);
  endtask

  // zero registers act as one, top offset, oversize sets
  task automatic test_clamped_config();
    cfg_write(scru_pkg::REG_VERTEX_COUNT, 32'd0);
    cfg_write(scru_pkg::REG_MAX_SET_SIZE, 32'd0);
    cfg_write(scru_pkg::REG_VERTEX_OFFSET, 32'hFFFF);
    send_encode(16'hFFFF, 1'b1);
    send_encode(16'h0000, 1'b1);  // label below offset
    send_decode('0, scru_pkg::DIM_W'(1));   // two vertices over a one-vertex limit
    send_decode(scru_pkg::CODE_W'(1), scru_pkg::DIM_W'(0));
    wait_idle(SETTLE_CYCLES);
    cfg_write(scru_pkg::REG_VERTEX_COUNT, 32'd3);
    cfg_write(scru_pkg::REG_MAX_SET_SIZE, 32'd2);
    cfg_write(scru_pkg::REG_VERTEX_OFFSET, 32'd100);
    send_encode(scru_pkg::LABEL_W'(100), 1'b0);
    send_encode(scru_pkg::LABEL_W'(101), 1'b0);
    send_encode(scru_pkg::LABEL_W'(102), 1'b1);  // third vertex over a limit of two
    wait_idle(SETTLE_CYCLES);
  endtask

  // random phases, the first at the top point count and set size
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        cfg_write(scru_pkg::REG_VERTEX_COUNT, 32'h1FF);
        cfg_write(scru_pkg::REG_MAX_SET_SIZE, 32'hF);
        cfg_write(scru_pkg::REG_VERTEX_OFFSET, 32'd0);
      end else begin
        random_config();
      end
      random_items(80);
      wait_idle(SETTLE_CYCLES);
    end
  endtask

  // full rate on both channels
  task automatic test_back_to_back();
    steady = 1'b1;
    random_config();
    random_items(80);
    wait_idle(SETTLE_CYCLES);
    steady = 1'b0;
  endtask

  initial begin : main
    int row, col;
    logic [63:0] a, b;
    for (row = 0; row <= scru_pkg::MAX_POINTS; row++) begin
      for (col = 0; col <= scru_pkg::MAX_K; col++) begin
        if (col == 0) begin
          pascal[row][col] = 64'd1;
        end else if (row == 0) begin
          pascal[row][col] = '0;
        end else begin
          a = pascal[row-1][col-1];
          b = pascal[row-1][col];
          pascal[row][col] = (a >= scru_pkg::BIN_SAT - b) ? scru_pkg::BIN_SAT : a + b;
        end
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_clamped_config();
    test_random_traffic();
    test_back_to_back();
    wait_idle(TAIL_CYCLES);
    if (code_vertex_q.size() != 0)
      report_mismatch("results never seen", code_vertex_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
